FILE: rtl/lpr_pkg.sv
package lpr_pkg;

  localparam int FramesDef   = 16;
  localparam int PageBitsDef = 16;

  // fixed field widths at the ports
  localparam int PageW   = 16;
  localparam int CfgW    = 5;
  localparam int FrameIdxW = 4;
  localparam int FaultW  = 32;

  // broadcast from the controller to every cell in the update cycle
  typedef struct packed {
    logic upd;      // apply the update this cycle
    logic age_all;  // fill: every valid frame ages by one
    logic load;     // selected frame takes the new tag
  } cell_ctl_t;

endpackage

FILE: rtl/lpr_cell.sv
module lpr_cell #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  parameter int CELL_IDX  = 0,
  parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lpr_pkg::cell_ctl_t    ctl_i,
  input  logic [PAGE_BITS-1:0]  page_i,
  input  logic [IDX_W-1:0]      lru_rank_i,
  input  logic [IDX_W-1:0]      sel_idx_i,
  input  logic [IDX_W-1:0]      old_rank_i,
  // lookup chain, from the lower-numbered neighbor
  input  logic                  hit_i,
  input  logic [IDX_W-1:0]      hit_idx_i,
  input  logic [IDX_W-1:0]      hit_rank_i,
  input  logic [IDX_W-1:0]      lru_idx_i,
  input  logic [PAGE_BITS-1:0]  lru_tag_i,
  // lookup chain, to the higher-numbered neighbor
  output logic                  hit_o,
  output logic [IDX_W-1:0]      hit_idx_o,
  output logic [IDX_W-1:0]      hit_rank_o,
  output logic [IDX_W-1:0]      lru_idx_o,
  output logic [PAGE_BITS-1:0]  lru_tag_o
);
  import lpr_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [PAGE_BITS-1:0] tag_q;
  logic                 valid_q;
  logic [IDX_W-1:0]     rank_q, rank_d;
  logic                 valid_d;
  logic                 hit_here, lru_here, sel;

  // tags of valid frames are distinct, and so are their ranks: at most one
  // cell sets each flag, so the chain just ORs contributions together
  assign hit_here = valid_q && (tag_q == page_i);
  assign lru_here = valid_q && (rank_q == lru_rank_i);

  assign hit_o      = hit_i | hit_here;
  assign hit_idx_o  = hit_idx_i  | (hit_here ? MyIdx  : '0);
  assign hit_rank_o = hit_rank_i | (hit_here ? rank_q : '0);
  assign lru_idx_o  = lru_idx_i  | (lru_here ? MyIdx  : '0);
  assign lru_tag_o  = lru_tag_i  | (lru_here ? tag_q  : '0);

  assign sel = (sel_idx_i == MyIdx);

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (ctl_i.upd) begin
      if (sel) begin
        valid_d = 1'b1;
        rank_d  = '0;
      end else if (valid_q && (ctl_i.age_all || (rank_q < old_rank_i))) begin
        rank_d = rank_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd && sel && ctl_i.load) begin
      tag_q <= page_i;
    end
  end

endmodule

FILE: rtl/lru_page_replacement.sv
// LRU page replacement over a row of frame cells.
// Each access passes through a lookup state (through the cell chain) and an
// update state; its result is registered on the ports with done_o high after
// the update state. A new access can be accepted in the update state, but not
// in the lookup state. busy_o is high during the lookup cycle only. Results cannot be stalled.
// Reset clears frames, ranks, fill count and fault total; frame count = FRAMES.
module lru_page_replacement #(
  parameter int FRAMES    = lpr_pkg::FramesDef,
  parameter int PAGE_BITS = lpr_pkg::PageBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lpr_pkg::CfgW-1:0]        cfg_wdata_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [lpr_pkg::PageW-1:0]       page_i,
  output logic                            done_o,
  output logic                            hit_o,
  output logic [lpr_pkg::FrameIdxW-1:0]   frame_index_o,
  output logic                            evicted_valid_o,
  output logic [lpr_pkg::PageW-1:0]       victim_page_o,
  output logic [lpr_pkg::FaultW-1:0]      fault_total_o
);
  import lpr_pkg::*;

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FILL_W = $clog2(FRAMES + 1);
  localparam int CNT_W  = (FILL_W > CfgW) ? FILL_W : CfgW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      frame_count_q;
  logic [FILL_W-1:0]     filled_q, filled_d;
  logic [FaultW-1:0]     fault_counter_q, fault_counter_d;
  logic [PAGE_BITS-1:0]  page_q;
  logic                  accept;

  // chain taps
  logic                  ch_hit  [FRAMES+1];
  logic [IDX_W-1:0]      ch_hidx [FRAMES+1];
  logic [IDX_W-1:0]      ch_hrank[FRAMES+1];
  logic [IDX_W-1:0]      ch_lidx [FRAMES+1];
  logic [PAGE_BITS-1:0]  ch_ltag [FRAMES+1];

  // lookup results, registered at the end of the lookup cycle
  logic                  any_hit_q;
  logic [IDX_W-1:0]      hit_idx_q, hit_rank_q, lru_idx_q;
  logic [PAGE_BITS-1:0]  lru_tag_q;

  cell_ctl_t             ctl;
  logic [IDX_W-1:0]      sel_idx, old_rank, lru_rank;
  logic [CNT_W-1:0]      limit;
  logic                  fill, evict;

  assign busy_o = (state_q == ST_LOOK);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_UPD;
      ST_UPD:  state_d = accept ? ST_LOOK : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // valid frames occupy 0..filled-1 and their ranks are 0..filled-1
  assign lru_rank = IDX_W'(filled_q - FILL_W'(1));

  always_comb begin
    if (frame_count_q == '0) begin
      limit = CNT_W'(1);
    end else if (frame_count_q > CNT_W'(FRAMES)) begin
      limit = CNT_W'(FRAMES);
    end else begin
      limit = frame_count_q;
    end
  end

  assign fill  = !any_hit_q && (CNT_W'(filled_q) < limit);
  assign evict = !any_hit_q && !fill;

  always_comb begin
    ctl.upd     = (state_q == ST_UPD);
    ctl.age_all = fill;
    ctl.load    = !any_hit_q;
    priority if (any_hit_q) begin
      sel_idx  = hit_idx_q;
      old_rank = hit_rank_q;
    end else if (fill) begin
      sel_idx  = IDX_W'(filled_q);
      old_rank = '0;
    end else begin
      sel_idx  = lru_idx_q;
      old_rank = lru_rank;
    end
  end

  always_comb begin
    filled_d        = filled_q;
    fault_counter_d = fault_counter_q;
    if (ctl.upd) begin
      if (fill) filled_d = filled_q + FILL_W'(1);
      if (!any_hit_q && (fault_counter_q != '1)) begin
        fault_counter_d = fault_counter_q + FaultW'(1);
      end
    end
  end

  assign ch_hit[0]   = 1'b0;
  assign ch_hidx[0]  = '0;
  assign ch_hrank[0] = '0;
  assign ch_lidx[0]  = '0;
  assign ch_ltag[0]  = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lpr_cell #(
      .FRAMES   (FRAMES),
      .PAGE_BITS(PAGE_BITS),
      .CELL_IDX (g),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .page_i    (page_q),
      .lru_rank_i(lru_rank),
      .sel_idx_i (sel_idx),
      .old_rank_i(old_rank),
      .hit_i     (ch_hit[g]),
      .hit_idx_i (ch_hidx[g]),
      .hit_rank_i(ch_hrank[g]),
      .lru_idx_i (ch_lidx[g]),
      .lru_tag_i (ch_ltag[g]),
      .hit_o     (ch_hit[g+1]),
      .hit_idx_o (ch_hidx[g+1]),
      .hit_rank_o(ch_hrank[g+1]),
      .lru_idx_o (ch_lidx[g+1]),
      .lru_tag_o (ch_ltag[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      frame_count_q   <= CNT_W'(FRAMES);
      filled_q        <= '0;
      fault_counter_q <= '0;
      done_o          <= 1'b0;
    end else begin
      state_q         <= state_d;
      filled_q        <= filled_d;
      fault_counter_q <= fault_counter_d;
      done_o          <= ctl.upd;
      if (cfg_we_i) frame_count_q <= CNT_W'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) page_q <= PAGE_BITS'(page_i);
    if (state_q == ST_LOOK) begin
      any_hit_q  <= ch_hit[FRAMES];
      hit_idx_q  <= ch_hidx[FRAMES];
      hit_rank_q <= ch_hrank[FRAMES];
      lru_idx_q  <= ch_lidx[FRAMES];
      lru_tag_q  <= ch_ltag[FRAMES];
    end
    if (ctl.upd) begin
      hit_o           <= any_hit_q;
      frame_index_o   <= FrameIdxW'(sel_idx);
      evicted_valid_o <= evict;
      victim_page_o   <= evict ? PageW'(lru_tag_q) : '0;
    end
  end

  assign fault_total_o = fault_counter_q;

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("lookup cycle longer than one cycle");

  a_done_after_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |=> done_o)
    else $error("update cycle without result strobe");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && evicted_valid_o))
    else $error("hit reported with eviction");

  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(filled_q) <= CNT_W'(FRAMES))
    else $error("fill count beyond frame count");

  a_fault_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) && !any_hit_q |=> fault_total_o != '0)
    else $error("fault not counted");

endmodule

FILE: dv/lru_page_replacement_tb.sv
`timescale 1ns / 1ps

module lru_page_replacement_tb;

  localparam int Frames     = lpr_pkg::FramesDef;
  localparam int PageW      = lpr_pkg::PageW;
  localparam int CfgW       = lpr_pkg::CfgW;
  localparam int FrameIdxW  = lpr_pkg::FrameIdxW;
  localparam int FaultW     = lpr_pkg::FaultW;
  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 4;
  localparam int MaxPrinted = 40;

  typedef struct packed {
    logic                 hit;
    logic [FrameIdxW-1:0] frame;
    logic                 ev_valid;
    logic [PageW-1:0]     ev_page;
    logic [FaultW-1:0]    faults;
  } access_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgW-1:0]      cfg_wdata_i;
  logic                 start_i;
  logic                 busy_o;
  logic [PageW-1:0]     page_i;
  logic                 done_o;
  logic                 hit_o;
  logic [FrameIdxW-1:0] frame_index_o;
  logic                 evicted_valid_o;
  logic [PageW-1:0]     victim_page_o;
  logic [FaultW-1:0]    fault_total_o;

  lru_page_replacement dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .page_i         (page_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .evicted_valid_o(evicted_valid_o),
    .victim_page_o  (victim_page_o),
    .fault_total_o  (fault_total_o)
  );

  // resident-set mirror
  logic [PageW-1:0]  res_tag [Frames];
  bit                res_valid [Frames];
  int unsigned       res_rank [Frames];
  int unsigned       res_filled = 0;
  logic [FaultW-1:0] res_faults = '0;
  logic [CfgW-1:0]   frame_limit = CfgW'(Frames);

  access_result_t expected_results [$];
  access_result_t want;
  int mismatch_count = 0;
  int cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int effective_frames(input logic [CfgW-1:0] c);
    if (c == 0) return 1;
    if (c > Frames) return Frames;
    return int'(c);
  endfunction

  // frame f becomes most recent; valid frames younger than old_rank age by one
  function automatic void age_and_promote(input int f, input int unsigned old_rank);
    for (int i = 0; i < Frames; i++)
      if (res_valid[i] && i != f && res_rank[i] < old_rank) res_rank[i]++;
    res_rank[f] = 0;
  endfunction

  function automatic access_result_t lru_access(input logic [PageW-1:0] pg);
    access_result_t r;
    int f;
    bit found;
    bit any;
    int unsigned best;
    r = '0;
    f = 0;
    found = 0;
    any = 0;
    best = 0;
    for (int i = 0; i < Frames; i++)
      if (!found && res_valid[i] && res_tag[i] == pg) begin
        f = i;
        found = 1;
      end
    if (found) begin
      r.hit = 1'b1;
      age_and_promote(f, res_rank[f]);
    end else begin
      if (res_faults != '1) res_faults++;
      if (res_filled < effective_frames(frame_limit)) begin
        // lowest free frame
        for (int i = Frames - 1; i >= 0; i--)
          if (!res_valid[i]) f = i;
        res_valid[f] = 1'b1;
        res_tag[f] = pg;
        res_filled++;
        age_and_promote(f, Frames + 1);
      end else begin
        for (int i = 0; i < Frames; i++)
          if (res_valid[i] && (!any || res_rank[i] > best)) begin
            best = res_rank[i];
            f = i;
            any = 1;
          end
        r.ev_valid = 1'b1;
        r.ev_page = res_tag[f];
        res_tag[f] = pg;
        age_and_promote(f, best);
      end
    end
    r.frame = f[FrameIdxW-1:0];
    r.faults = res_faults;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxPrinted) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (hit_o !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", hit_o, want.hit));
        if (frame_index_o !== want.frame)
          report_mismatch($sformatf("frame_index %0d, expected %0d",
                                    frame_index_o, want.frame));
        if (evicted_valid_o !== want.ev_valid)
          report_mismatch($sformatf("evicted_valid %b, expected %b",
                                    evicted_valid_o, want.ev_valid));
        if (victim_page_o !== want.ev_page)
          report_mismatch($sformatf("victim_page %h, expected %h",
                                    victim_page_o, want.ev_page));
        if (fault_total_o !== want.faults)
          report_mismatch($sformatf("fault_total %0d, expected %0d",
                                    fault_total_o, want.faults));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // start stays high across back-to-back transactions; callers lower it by pausing
  task automatic send_access(input logic [PageW-1:0] pg);
    @(negedge clk_i);
    start_i <= 1'b1;
    page_i <= pg;
    do @(posedge clk_i); while (busy_o);
    expected_results.insert(expected_results.size(), lru_access(pg));
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_frame_count(input logic [CfgW-1:0] v);
    wait_all_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    frame_limit = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_gap(input int idle_pct);
    int r;
    r = $urandom_range(99);
    if (r >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  // fill from reset with the full frame count, then hits, back to back
  task automatic test_fill_and_hit();
    send_access(16'h0000);
    send_access(16'hFFFF);
    send_access(16'hAAAA);
    send_access(16'h5555);
    send_access(16'h0000);
    send_access(16'hAAAA);
    send_access(16'hFFFF);
    pause_sender(1);
  endtask

  // frame count below the filled frames: resident pages stay, faults evict
  task automatic test_frame_count_shrink();
    write_frame_count(5'd2);
    send_access(16'h1234);
    send_access(16'h5555);
    send_access(16'h4321);
    pause_sender(2);
    send_access(16'h1234);
    pause_sender(1);
  endtask

  // zero acts as one, values past the built frame count act as the maximum
  task automatic test_frame_count_bounds();
    write_frame_count(5'd0);
    send_access(16'h0F0F);
    send_access(16'h0F0F);
    write_frame_count(5'd1);
    send_access(16'hF0F0);
    write_frame_count(5'd31);
    send_access(16'h00F0);
    send_access(16'h0F00);
    send_access(16'h00F0);
    write_frame_count(5'd16);
    send_access(16'h8001);
    send_access(16'h7FFE);
    pause_sender(1);
  endtask

  // mostly a working set a bit larger than the frame count, so hits and
  // evictions mix; some recent repeats and some fully random pages
  task automatic test_random_phase(input logic [CfgW-1:0] count, input int items,
                                   input int idle_pct);
    logic [PageW-1:0] pool [$];
    logic [PageW-1:0] recent [$];
    logic [PageW-1:0] pg;
    int sel;
    write_frame_count(count);
    repeat (effective_frames(count) + 3) pool.insert(pool.size(), PageW'($urandom));
    for (int n = 0; n < items; n++) begin
      sel = $urandom_range(99);
      if (sel < 60) pg = pool[$urandom_range(pool.size() - 1)];
      else if (sel < 85 && recent.size() > 0) pg = recent[$urandom_range(recent.size() - 1)];
      else pg = PageW'($urandom);
      if ($urandom_range(19) == 0) pool[$urandom_range(pool.size() - 1)] = PageW'($urandom);
      send_access(pg);
      recent.insert(recent.size(), pg);
      if (recent.size() > 4) recent.delete(0);
      if ($urandom_range(59) == 0) wait_all_results();
      else pause_sender(pick_gap(idle_pct));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    page_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fill_and_hit();
    test_frame_count_shrink();
    test_frame_count_bounds();
    test_random_phase(5'd8, 180, 30);
    test_random_phase(5'd12, 180, 0);
    test_random_phase(5'd16, 200, 40);
    test_random_phase(5'd1, 180, 30);
    test_random_phase(5'd31, 200, 20);
    test_random_phase(5'd0, 150, 30);
    test_random_phase(5'd5, 150, 50);
    test_random_phase(5'd16, 160, 0);

    wait_all_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
